// ===== rtl/mtc_pkg.sv =====
// shared types and constants of the markov transition counter
// payload structs of both channels, mode codes, controller states
// depends on nothing
package mtc_pkg;

	// fixed field widths of the channel payloads
	localparam int SYM_FIELD_W = 6;
	localparam int MODE_W      = 2;
	localparam int PROB_W      = 17;
	localparam int FRAC_BITS   = 16;
	localparam int COUNT_OUT_W = 16;
	localparam int TOTAL_OUT_W = 22;

	// token modes
	localparam logic [MODE_W-1:0] MODE_SYMBOL    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SEPARATOR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY     = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]      mode;
		logic [SYM_FIELD_W-1:0] symbol;
		logic [SYM_FIELD_W-1:0] query_from;
		logic [SYM_FIELD_W-1:0] query_to;
	} mtc_in_t;

	typedef struct packed {
		logic [PROB_W-1:0]      probability;
		logic [COUNT_OUT_W-1:0] pair_count;
		logic [TOTAL_OUT_W-1:0] row_total;
	} mtc_out_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TOKEN,
		ST_QLOAD,
		ST_QDIV,
		ST_QOUT
	} mtc_state_t;

endpackage

// ===== rtl/mtc_stream_if.sv =====
// valid/ready stream channel carrying one payload beat
// payload type is a parameter; depends on nothing
interface mtc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mtc_div.sv =====
// iterative fractional divider: floor(num * 2^16 / den), one quotient bit a cycle
// expects num <= den; gives 0 for a zero divisor; uses mtc_pkg
module mtc_div
	import mtc_pkg::*;
#(
	parameter int NUM_W = 16,
	parameter int DEN_W = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              done,
	output logic [PROB_W-1:0] quot
);

	localparam int STEP_W = $clog2(PROB_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROB_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic              zero_q;
	logic [PROB_W-1:0] q_q;

	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	// first step tests the integer bit, later steps shift in a zero
	always_comb begin
		trial = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DEN_W'(num);
			den_q  <= den;
			zero_q <= (den == '0);
			q_q    <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			q_q   <= {q_q[PROB_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = zero_q ? '0 : q_q;

endmodule

// ===== rtl/markov_transition_counter_top.sv =====
// top level of the markov transition counter
// count and row-total memories, token and query sequencing, result register
// depends on mtc_pkg, mtc_stream_if and mtc_div
//
//   channel   dir  payload                                  beat when
//   items     in   mode, symbol, query_from, query_to       valid & ready
//   results   out  probability, pair_count, row_total       valid & ready
//
// a symbol token reads the cell and the row total at its accepting edge and
// writes both back in the cycle after (single-port read-modify-write)
// separators and unused modes are taken without leaving the idle state; a
// query goes from its beat through the divider load, the divider (17 quotient
// bits, one a cycle, then done) and the result load into a free result register
// after reset a clearing pass zeroes the count memory one entry a cycle,
// all 2^(2*ceil(log2 NUM_SYMBOLS)) entries (4096 by default), with items held off
// a finished result waits in its own register; tokens go on meanwhile, and
// a query stalls only at its very end while that register is still full
module markov_transition_counter_top
	import mtc_pkg::*;
#(
	parameter int NUM_SYMBOLS = 64,
	parameter int COUNT_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	mtc_stream_if.sink    items,
	mtc_stream_if.source  results
);

	// index widths: cell address is {row, column}
	localparam int SYM_W     = $clog2(NUM_SYMBOLS);
	localparam int ADDR_W    = 2 * SYM_W;
	localparam int DEPTH     = 1 << ADDR_W;
	localparam int ROWS      = 1 << SYM_W;
	localparam int TOTAL_W   = COUNT_BITS + SYM_W;
	localparam int FLD_EXT_W = (SYM_W > SYM_FIELD_W) ? SYM_W : SYM_FIELD_W;
	localparam int CNT_EXT_W = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;
	localparam int TOT_EXT_W = (TOTAL_W > TOTAL_OUT_W) ? TOTAL_W : TOTAL_OUT_W;
	localparam logic [FLD_EXT_W:0] SYM_LIMIT = (FLD_EXT_W + 1)'(NUM_SYMBOLS);

	// controller
	mtc_state_t state_q, state_d;

	logic item_beat;
	logic is_symbol, is_sep, is_query;
	logic sym_ok, query_ok;

	logic [FLD_EXT_W-1:0] sym_ext, from_ext, to_ext;
	logic [SYM_W-1:0]     sym_idx, from_idx, to_idx;

	// chain state
	logic             last_valid_q;
	logic [SYM_W-1:0] last_sym_q;

	// clearing pass
	logic [ADDR_W-1:0] clr_q;
	logic              clr_last;

	// memories
	logic [COUNT_BITS-1:0] pair_mem [DEPTH];
	logic [TOTAL_W-1:0]    row_mem  [ROWS];
	logic [COUNT_BITS-1:0] pair_rd_q;
	logic [TOTAL_W-1:0]    row_rd_q;
	logic [ADDR_W-1:0]     pair_ra, pair_wa;
	logic [SYM_W-1:0]      row_ra, row_wa;
	logic [COUNT_BITS-1:0] pair_wd;
	logic [TOTAL_W-1:0]    row_wd;
	logic                  mem_we;

	// token in flight
	logic [ADDR_W-1:0] pair_addr_s1;
	logic [SYM_W-1:0]  row_addr_s1;
	logic              tok_inc_s1;
	logic              query_ok_s1;
	logic              sat;

	// fsm outputs
	logic ready_o;
	logic tok_wr;
	logic div_start;
	logic res_load;

	// query datapath
	logic [COUNT_BITS-1:0] cnt_sel, cnt_q;
	logic [TOTAL_W-1:0]    tot_sel, tot_q;
	logic [CNT_EXT_W-1:0]  cnt_ext;
	logic [TOT_EXT_W-1:0]  tot_ext;
	logic                  div_done;
	logic [PROB_W-1:0]     div_quot;

	// result register
	logic     res_valid_q;
	mtc_out_t res_q;
	logic     res_free;

	// field decode
	always_comb begin
		sym_ext   = FLD_EXT_W'(items.data.symbol);
		from_ext  = FLD_EXT_W'(items.data.query_from);
		to_ext    = FLD_EXT_W'(items.data.query_to);
		sym_idx   = sym_ext[SYM_W-1:0];
		from_idx  = from_ext[SYM_W-1:0];
		to_idx    = to_ext[SYM_W-1:0];
		sym_ok    = {1'b0, sym_ext} < SYM_LIMIT;
		query_ok  = ({1'b0, from_ext} < SYM_LIMIT) && ({1'b0, to_ext} < SYM_LIMIT);
		is_symbol = (items.data.mode == MODE_SYMBOL);
		is_sep    = (items.data.mode == MODE_SEPARATOR);
		is_query  = (items.data.mode == MODE_QUERY);
	end

	assign item_beat = items.valid && ready_o;
	assign clr_last  = (clr_q == ADDR_W'(DEPTH - 1));
	assign res_free  = !res_valid_q || results.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (items.valid) begin
					if (is_query) state_d = ST_QLOAD;
					else if (is_symbol && sym_ok) state_d = ST_TOKEN;
				end
			end
			ST_TOKEN: state_d = ST_IDLE;
			ST_QLOAD: state_d = ST_QDIV;
			ST_QDIV: begin
				if (div_done) state_d = ST_QOUT;
			end
			ST_QOUT: begin
				if (res_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		ready_o   = 1'b0;
		tok_wr    = 1'b0;
		div_start = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: ;
			ST_IDLE:  ready_o   = 1'b1;
			ST_TOKEN: tok_wr    = 1'b1;
			ST_QLOAD: div_start = 1'b1;
			ST_QDIV:  ;
			ST_QOUT:  res_load  = res_free;
			default:  ;
		endcase
	end

	assign items.ready = ready_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// chain tracking: a query leaves the chain alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_valid_q <= 1'b0;
			last_sym_q   <= '0;
		end else if (item_beat) begin
			if (is_symbol) begin
				if (sym_ok) begin
					last_valid_q <= 1'b1;
					last_sym_q   <= sym_idx;
				end else begin
					last_valid_q <= 1'b0;
				end
			end else if (is_sep) begin
				last_valid_q <= 1'b0;
			end
		end
	end

	// read addresses come straight from the accepted beat and the last chain symbol
	always_comb begin
		if (is_query) begin
			pair_ra = {from_idx, to_idx};
			row_ra  = from_idx;
		end else begin
			pair_ra = {last_sym_q, sym_idx};
			row_ra  = last_sym_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_inc_s1 <= 1'b0;
		end else if (item_beat) begin
			tok_inc_s1 <= is_symbol && sym_ok && last_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (item_beat) begin
			pair_addr_s1 <= pair_ra;
			row_addr_s1  <= row_ra;
			query_ok_s1  <= query_ok;
		end
	end

	// write-back: saturated cell leaves both cell and row total untouched
	assign sat = (pair_rd_q == '1);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we  = 1'b1;
			pair_wa = clr_q;
			row_wa  = clr_q[SYM_W-1:0];
			pair_wd = '0;
			row_wd  = '0;
		end else begin
			mem_we  = tok_wr && tok_inc_s1 && !sat;
			pair_wa = pair_addr_s1;
			row_wa  = row_addr_s1;
			pair_wd = pair_rd_q + 1'b1;
			row_wd  = row_rd_q + 1'b1;
		end
	end

	// count memory
	always_ff @(posedge clk) begin
		if (mem_we) pair_mem[pair_wa] <= pair_wd;
		if (item_beat) pair_rd_q <= pair_mem[pair_ra];
	end

	// row total memory
	always_ff @(posedge clk) begin
		if (mem_we) row_mem[row_wa] <= row_wd;
		if (item_beat) row_rd_q <= row_mem[row_ra];
	end

	// query: out-of-range cell reads as empty, which also zeroes the ratio
	always_comb begin
		cnt_sel = query_ok_s1 ? pair_rd_q : '0;
		tot_sel = query_ok_s1 ? row_rd_q : '0;
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			cnt_q <= cnt_sel;
			tot_q <= tot_sel;
		end
	end

	mtc_div #(
		.NUM_W (COUNT_BITS),
		.DEN_W (TOTAL_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (cnt_sel),
		.den    (tot_sel),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign cnt_ext = CNT_EXT_W'(cnt_q);
	assign tot_ext = TOT_EXT_W'(tot_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.probability <= div_quot;
			res_q.pair_count  <= cnt_ext[COUNT_OUT_W-1:0];
			res_q.row_total   <= tot_ext[TOTAL_OUT_W-1:0];
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

endmodule
